// ===== hw/rtl/c2d_pkg.sv =====
// Shared types and constants of the 3x3 zero-padded convolution block.
// Used by the front end, the job queue, the back end and the top level.
package c2d_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 8;
  localparam int KSIZE       = 3;
  localparam int WIN_N       = KSIZE * KSIZE;
  localparam int NRES        = 4;
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int FRAME_REG_W = 8;
  localparam int FRAME_RESET = 128;

  typedef logic [CFG_ADDR_W-1:0] c2d_reg_idx_t;

  localparam c2d_reg_idx_t REG_FRAME_ROWS = 3'd0;
  localparam c2d_reg_idx_t REG_FRAME_COLS = 3'd1;
  localparam c2d_reg_idx_t REG_KERNEL_TOP = 3'd2;
  localparam c2d_reg_idx_t REG_KERNEL_MID = 3'd3;
  localparam c2d_reg_idx_t REG_KERNEL_BOT = 3'd4;

  // Window entry r*3+c: row 0 is the oldest row, column 0 the oldest column.
  typedef logic [WIN_N-1:0][SAMPLE_W-1:0] c2d_win_t;

  // One kernel row per entry, column 0 in the low bits.
  typedef logic [KSIZE-1:0][KSIZE*SAMPLE_W-1:0] c2d_kern_t;

  // Work for the back end: a window snapshot and which of the four
  // neighbor results it produces (bit 0 center, 1 right edge, 2 bottom, 3 corner).
  typedef struct packed {
    c2d_win_t          win;
    logic [NRES-1:0]   mask;
  } c2d_job_t;

endpackage

// ===== hw/rtl/c2d_front.sv =====
// Front end: accepts pixels, keeps row/column counters, the two line buffers
// and the 3x3 window, and queues a job per pixel with results. Uses c2d_pkg.
module c2d_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  logic [RW-1:0]                     last_row,
  input  logic [CW-1:0]                     last_col,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [c2d_pkg::SAMPLE_W-1:0]      in_pixel,
  input  logic [c2d_pkg::QCNT_W-1:0]        q_count,
  output logic                              push,
  output c2d_pkg::c2d_job_t                 job,
  output logic [RW-1:0]                     job_row,
  output logic [CW-1:0]                     job_col
);
  import c2d_pkg::*;

  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic                acc, at_last_col, at_last_row;
  logic [NRES-1:0]     mask_nxt;

  logic                f1_v_r;
  logic [SAMPLE_W-1:0] f1_pix_r;
  logic [RW-1:0]       f1_row_r;
  logic [CW-1:0]       f1_col_r;
  logic [NRES-1:0]     f1_mask_r;
  logic                f1_clr_r, f1_top_ok_r, f1_mid_ok_r;

  logic [SAMPLE_W-1:0] lp_mem  [MAX_WIDTH];
  logic [SAMPLE_W-1:0] lp2_mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0] lp_rd_r, lp2_rd_r, byp_d_r, prev2;
  logic                byp_r;

  c2d_win_t            win_r, win_nxt;

  // Room must remain for the word still in the read stage.
  assign in_ready = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(f1_v_r) < (QCNT_W + 1)'(Q_DEPTH);
  assign acc      = in_valid && in_ready;

  assign at_last_col = (col_r == last_col);
  assign at_last_row = (row_r == last_row);

  always_comb begin
    if (at_last_col) begin
      col_nxt = '0;
      row_nxt = at_last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
    mask_nxt[0] = (row_r != '0) && (col_r != '0);
    mask_nxt[1] = (row_r != '0) && at_last_col;
    mask_nxt[2] = at_last_row && (col_r != '0);
    mask_nxt[3] = at_last_row && at_last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r  <= '0;
      col_r  <= '0;
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= acc;
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_pix_r    <= in_pixel;
      f1_row_r    <= row_r;
      f1_col_r    <= col_r;
      f1_mask_r   <= mask_nxt;
      f1_clr_r    <= (col_r == '0);
      f1_top_ok_r <= (row_r > RW'(1));
      f1_mid_ok_r <= (row_r != '0);
    end
  end

  // Line buffers: the newest row is written on accept, the older one in the
  // following cycle from the registered read. A one-column frame reads that
  // same entry in the cycle it is written, so the value is forwarded.
  always_ff @(posedge clk) begin
    if (acc) begin
      lp_mem[col_r] <= in_pixel;
      lp_rd_r       <= lp_mem[col_r];
      lp2_rd_r      <= lp2_mem[col_r];
      byp_r         <= f1_v_r && (f1_col_r == col_r);
      byp_d_r       <= lp_rd_r;
    end
    if (f1_v_r) begin
      lp2_mem[f1_col_r] <= lp_rd_r;
    end
  end

  assign prev2 = byp_r ? byp_d_r : lp2_rd_r;

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      win_nxt[r*KSIZE]     = f1_clr_r ? '0 : win_r[r*KSIZE + 1];
      win_nxt[r*KSIZE + 1] = f1_clr_r ? '0 : win_r[r*KSIZE + 2];
    end
    win_nxt[2] = f1_top_ok_r ? prev2 : '0;
    win_nxt[5] = f1_mid_ok_r ? lp_rd_r : '0;
    win_nxt[8] = f1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (f1_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign push     = f1_v_r && (f1_mask_r != '0);
  assign job.win  = win_nxt;
  assign job.mask = f1_mask_r;
  assign job_row  = f1_row_r;
  assign job_col  = f1_col_r;

endmodule

// ===== hw/rtl/c2d_queue.sv =====
// Short first-in first-out queue of jobs between front and back end.
// Depth and count width come from c2d_pkg.
module c2d_queue #(
  parameter int WIDTH = 160
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [c2d_pkg::QCNT_W-1:0] count
);
  import c2d_pkg::*;

  logic [WIDTH-1:0]  mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

// ===== hw/rtl/c2d_back.sv =====
// Back end: walks the head job's results, one per cycle unless the output stalls,
// multiplies in one stage, sums in the next and holds the output word. Uses c2d_pkg.
module c2d_back #(
  parameter int RW = 7,
  parameter int CW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c2d_pkg::c2d_kern_t            kern,
  input  logic                          q_empty,
  input  c2d_pkg::c2d_job_t             q_job,
  input  logic [RW-1:0]                 q_row,
  input  logic [CW-1:0]                 q_col,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c2d_pkg::SAMPLE_W-1:0]  out_value,
  output logic [RW-1:0]                 out_row,
  output logic [CW-1:0]                 out_col,
  output logic                          out_last,
  output logic                          out_done
);
  import c2d_pkg::*;

  logic [NRES-1:0]     done_r, rem, pick;
  logic [1:0]          k;
  logic                adv, issue, pick_last;
  c2d_win_t            prod_nxt, a_prod_r;
  logic                a_v_r, a_last_r, a_done_r;
  logic [RW-1:0]       a_row_r;
  logic [CW-1:0]       a_col_r;
  logic [SAMPLE_W-1:0] sum;

  logic                out_v_r, out_last_r, out_done_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic [RW-1:0]       out_row_r;
  logic [CW-1:0]       out_col_r;

  assign adv   = !out_v_r || out_ready;
  assign issue = adv && !q_empty;
  assign rem   = q_job.mask & ~done_r;

  always_comb begin
    pick = '0;
    k    = 2'd0;
    if (rem[0]) begin
      pick[0] = 1'b1; k = 2'd0;
    end else if (rem[1]) begin
      pick[1] = 1'b1; k = 2'd1;
    end else if (rem[2]) begin
      pick[2] = 1'b1; k = 2'd2;
    end else begin
      pick[3] = 1'b1; k = 2'd3;
    end
  end

  assign pick_last = ((rem & ~pick) == '0);
  assign q_pop     = issue && pick_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (issue) begin
      done_r <= pick_last ? '0 : (done_r | pick);
    end
  end

  // Shifting the window by (k[1], k[0]) moves the kernel onto the right or
  // lower neighbor; taps that fall outside are zero padding. Products are
  // floored to the sample's fraction and only the low sample bits are kept.
  always_comb begin
    logic signed [SAMPLE_W-1:0]   c, s;
    logic signed [2*SAMPLE_W-1:0] p;
    int                           r, q;
    for (int ki = 0; ki < KSIZE; ki++) begin
      for (int kj = 0; kj < KSIZE; kj++) begin
        r = ki + int'(k[1]);
        q = kj + int'(k[0]);
        c = kern[ki][kj*SAMPLE_W +: SAMPLE_W];
        s = (r < KSIZE && q < KSIZE) ? q_job.win[r*KSIZE + q] : '0;
        p = c * s;
        prod_nxt[ki*KSIZE + kj] = p[FRAC_W + SAMPLE_W - 1:FRAC_W];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_N; i++) begin
      sum = sum + a_prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r   <= !q_empty;
      out_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r    <= prod_nxt;
      a_row_r     <= q_row + RW'(k[1]) - RW'(1);
      a_col_r     <= q_col + CW'(k[0]) - CW'(1);
      a_last_r    <= pick_last;
      a_done_r    <= pick[3];
      out_value_r <= sum;
      out_row_r   <= a_row_r;
      out_col_r   <= a_col_r;
      out_last_r  <= a_last_r;
      out_done_r  <= a_done_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

// ===== hw/rtl/conv2d_3x3_zero_pad.sv =====
// Top level of the streaming 3x3 convolution with zero padding.
// Holds the configuration registers and joins c2d_front, c2d_queue and c2d_back.
//
// Pixels arrive in raster order, one word per clock while in_tready is high,
// and each result at (r, c) leaves once pixel (r+1, c+1) or the nearest
// pixel in the frame has arrived, so a pixel yields zero to four results.
// The back end issues one result per clock unless the output stalls, which
// sets the rate: inside the frame one pixel per cycle, at the right column
// and along the bottom row up to two results per pixel, and the last pixel
// of a frame up to four; the four-entry job queue absorbs these bursts.
// No clearing pass follows reset. Frame size writes restart the frame; all
// configuration must be written by the user while the block is idle; the
// block itself does not enforce this.
module conv2d_3x3_zero_pad #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  localparam int RW          = $clog2(MAX_HEIGHT),
  localparam int CW          = $clog2(MAX_WIDTH),
  localparam int OUT_BITS    = c2d_pkg::SAMPLE_W + RW + CW,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [c2d_pkg::SAMPLE_W-1:0]    in_tdata,   // pixel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_TDATA_W-1:0]          out_tdata,  // value, out_row, out_col, zero fill
  output logic                            out_tlast,  // run_last
  output logic                            out_tuser,  // frame_done
  input  logic                            cfg_wr_en,
  input  logic [c2d_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import c2d_pkg::*;

  localparam int JOB_W = $bits(c2d_job_t) + RW + CW;

  logic [RW-1:0]      last_row_r;
  logic [CW-1:0]      last_col_r;
  c2d_kern_t          kern_r;
  logic               restart;
  logic [31:0]        frame_val;

  logic               q_push, q_pop, q_empty;
  logic [QCNT_W-1:0]  q_count;
  c2d_job_t           f_job, q_job;
  logic [RW-1:0]      f_row, q_row, o_row;
  logic [CW-1:0]      f_col, q_col, o_col;
  logic [JOB_W-1:0]   q_wr, q_rd;
  logic [SAMPLE_W-1:0] o_value;

  // Frame sizes are kept as the index of the last row or column.
  function automatic int last_index(input int v, input int maxv);
    if (v == 0)         last_index = 0;
    else if (v > maxv)  last_index = maxv - 1;
    else                last_index = v - 1;
  endfunction

  assign frame_val = 32'(cfg_wdata[FRAME_REG_W-1:0]);
  assign restart   = cfg_wr_en && (cfg_addr == REG_FRAME_ROWS || cfg_addr == REG_FRAME_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= RW'(last_index(FRAME_RESET, MAX_HEIGHT));
      last_col_r <= CW'(last_index(FRAME_RESET, MAX_WIDTH));
      kern_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_ROWS: last_row_r <= RW'(last_index(int'(frame_val), MAX_HEIGHT));
        REG_FRAME_COLS: last_col_r <= CW'(last_index(int'(frame_val), MAX_WIDTH));
        REG_KERNEL_TOP: kern_r[0]  <= cfg_wdata;
        REG_KERNEL_MID: kern_r[1]  <= cfg_wdata;
        REG_KERNEL_BOT: kern_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  c2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .last_row (last_row_r),
    .last_col (last_col_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .q_count  (q_count),
    .push     (q_push),
    .job      (f_job),
    .job_row  (f_row),
    .job_col  (f_col)
  );

  assign q_wr = {f_col, f_row, f_job};

  c2d_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty),
    .count   (q_count)
  );

  assign q_job = q_rd[$bits(c2d_job_t)-1:0];
  assign q_row = q_rd[$bits(c2d_job_t) +: RW];
  assign q_col = q_rd[$bits(c2d_job_t) + RW +: CW];

  c2d_back #(
    .RW (RW),
    .CW (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kern      (kern_r),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_row     (q_row),
    .q_col     (q_col),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (o_value),
    .out_row   (o_row),
    .out_col   (o_col),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({o_col, o_row, o_value});

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != QCNT_W'(Q_DEPTH)))
    else $error("job queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  a_frame_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && o_row == last_row_r && o_col == last_col_r))
    else $error("frame end flagged away from the last pixel of the frame");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for conv2d_3x3_zero_pad: pixel frames in, checked results out.
// Depends on c2d_pkg and the block's RTL only; a scoreboard class predicts each result.
module testbench;
  import c2d_pkg::*;

  localparam int MAX_DIM       = 128;
  localparam int IDX_W         = $clog2(MAX_DIM);
  localparam int OUT_W         = ((SAMPLE_W + 2 * IDX_W + 7) / 8) * 8;
  localparam int ROW_LSB       = SAMPLE_W;
  localparam int COL_LSB       = SAMPLE_W + IDX_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SMALL_PX      = 8;
  localparam c2d_reg_idx_t REG_SPARE_LO = REG_KERNEL_BOT + 3'd1;
  localparam c2d_reg_idx_t REG_SPARE_HI = '1;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic                run_last;
    logic                frame_done;
  } conv_result_t;

  class conv_scoreboard;
    logic [FRAME_REG_W-1:0]      rows_cfg;
    logic [FRAME_REG_W-1:0]      cols_cfg;
    logic [KSIZE*SAMPLE_W-1:0]   kern [KSIZE];
    logic [SAMPLE_W-1:0]         line_up1 [MAX_DIM];
    logic [SAMPLE_W-1:0]         line_up2 [MAX_DIM];
    logic [SAMPLE_W-1:0]         win [WIN_N];
    int unsigned                 row_i;
    int unsigned                 col_j;
    conv_result_t                due_results [$];
    int                          errors;
    int                          pixels_taken;
    int                          results_checked;

    function new();
      rows_cfg = FRAME_REG_W'(FRAME_RESET);
      cols_cfg = FRAME_REG_W'(FRAME_RESET);
      foreach (kern[k]) kern[k] = '0;
      foreach (line_up1[k]) begin
        line_up1[k] = '0;
        line_up2[k] = '0;
      end
      restart();
      errors = 0;
      pixels_taken = 0;
      results_checked = 0;
    endfunction

    function void restart();
      row_i = 0;
      col_j = 0;
      foreach (win[k]) win[k] = '0;
    endfunction

    // A size of zero acts as one, anything above the line buffer depth as the depth.
    function int unsigned clamp_dim(logic [FRAME_REG_W-1:0] v);
      if (v == 0) return 1;
      return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function void write_reg(c2d_reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_ROWS: begin
          rows_cfg = data[FRAME_REG_W-1:0];
          restart();
        end
        REG_FRAME_COLS: begin
          cols_cfg = data[FRAME_REG_W-1:0];
          restart();
        end
        REG_KERNEL_TOP: kern[0] = data;
        REG_KERNEL_MID: kern[1] = data;
        REG_KERNEL_BOT: kern[2] = data;
        default: ;
      endcase
    endfunction

    // Kernel (ki,kj) meets window (ki+dr, kj+dc); anything shifted off the window is padding.
    // Each product is floored to Q8.8 and the sum wraps at the sample width.
    function logic [SAMPLE_W-1:0] window_sum(int dr, int dc);
      logic [SAMPLE_W-1:0]          acc;
      logic signed [SAMPLE_W-1:0]   c;
      logic signed [SAMPLE_W-1:0]   s;
      logic signed [2*SAMPLE_W-1:0] p;
      acc = '0;
      for (int ki = 0; ki < KSIZE; ki++) begin
        for (int kj = 0; kj < KSIZE; kj++) begin
          if (ki + dr < KSIZE && kj + dc < KSIZE) begin
            c = kern[ki][kj*SAMPLE_W +: SAMPLE_W];
            s = win[(ki + dr) * KSIZE + kj + dc];
            p = c * s;
            acc += SAMPLE_W'(p >>> FRAC_W);
          end
        end
      end
      return acc;
    endfunction

    function void take_pixel(logic [SAMPLE_W-1:0] px);
      conv_result_t res [NRES];
      int           n;
      int           dr;
      int           dc;
      int unsigned  nr;
      int unsigned  nc;
      int unsigned  i;
      int unsigned  j;
      bit           last_col;
      bit           last_row;
      bit           ok;
      nr = clamp_dim(rows_cfg);
      nc = clamp_dim(cols_cfg);
      i = row_i;
      j = col_j;
      if (i >= nr || j >= nc) begin
        i = 0;
        j = 0;
        foreach (win[k]) win[k] = '0;
      end
      last_col = (j == nc - 1);
      last_row = (i == nr - 1);
      if (j == 0) foreach (win[k]) win[k] = '0;
      for (int r = 0; r < KSIZE; r++) begin
        win[r*KSIZE]     = win[r*KSIZE + 1];
        win[r*KSIZE + 1] = win[r*KSIZE + 2];
      end
      win[KSIZE - 1]     = (i >= 2) ? line_up2[j] : '0;
      win[2*KSIZE - 1]   = (i >= 1) ? line_up1[j] : '0;
      win[WIN_N - 1]     = px;
      line_up2[j] = line_up1[j];
      line_up1[j] = px;

      // Neighbors in order: center, right edge, bottom edge, corner.
      n = 0;
      for (int k = 0; k < NRES; k++) begin
        dr = k >> 1;
        dc = k & 1;
        ok = (dr ? last_row : (i >= 1)) && (dc ? last_col : (j >= 1));
        if (ok) begin
          res[n].value      = window_sum(dr, dc);
          res[n].row        = IDX_W'(i - 1 + dr);
          res[n].col        = IDX_W'(j - 1 + dc);
          res[n].run_last   = 1'b0;
          res[n].frame_done = (dr == 1 && dc == 1);
          n++;
        end
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int k = 0; k < n; k++) due_results.push_back(res[k]);

      if (last_col) begin
        col_j = 0;
        row_i = last_row ? 0 : i + 1;
      end else begin
        col_j = j + 1;
        row_i = i;
      end
      pixels_taken++;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] tdata, logic tlast, logic tuser);
      conv_result_t        want;
      logic [SAMPLE_W-1:0] value;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      value = tdata[SAMPLE_W-1:0];
      row   = tdata[ROW_LSB +: IDX_W];
      col   = tdata[COL_LSB +: IDX_W];
      if (due_results.size() == 0) begin
        report($sformatf("result %h at (%0d,%0d) with nothing pending", value, row, col));
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      if (value !== want.value || row !== want.row || col !== want.col ||
          tlast !== want.run_last || tuser !== want.frame_done)
        report($sformatf("got val %h (%0d,%0d) last %b done %b, want val %h (%0d,%0d) last %b done %b",
                         value, row, col, tlast, tuser, want.value, want.row, want.col,
                         want.run_last, want.frame_done));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  conv_scoreboard      sb;
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  cycle_count = 0;
  int                  frame_setups = 0;
  logic [SAMPLE_W-1:0] extreme_px [9];

  conv2d_3x3_zero_pad dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results still outstanding", sb.due_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] px);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_pixel(px);
    @(negedge clk);
  endtask

  task automatic write_cfg(input c2d_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // The last pixel may have produced nothing yet still be in flight, so settle a while.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_pixel();
    if ($urandom_range(7) == 0) return extreme_px[$urandom_range(8)];
    return SAMPLE_W'($urandom);
  endfunction

  // Half the rows use full-range coefficients, half stay within +-2.0 so sums stay readable.
  function automatic logic [CFG_DATA_W-1:0] rand_kernel_row();
    logic [CFG_DATA_W-1:0] row_w;
    int                    c;
    if ($urandom_range(1)) return CFG_DATA_W'({$urandom, $urandom});
    for (int k = 0; k < KSIZE; k++) begin
      c = int'($urandom_range(1023)) - 512;
      row_w[k*SAMPLE_W +: SAMPLE_W] = c[SAMPLE_W-1:0];
    end
    return row_w;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] rows_w;
    logic [CFG_DATA_W-1:0] cols_w;
    int                    mode_px;
    int                    frame_px;
    bit                    resize;

    sb = new();
    extreme_px = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0100,
                   16'h0001, 16'h8000, 16'h7FFF, 16'hFF00};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a 3x3 frame of extreme samples against extreme coefficients.
    write_cfg(REG_FRAME_ROWS, 3);
    write_cfg(REG_FRAME_COLS, 3);
    write_cfg(REG_KERNEL_TOP, {16'h8000, 16'h7FFF, 16'h0100});
    write_cfg(REG_KERNEL_MID, {16'hFFFF, 16'h0080, 16'h7FFF});
    write_cfg(REG_KERNEL_BOT, {16'h0001, 16'h8000, 16'hFF00});
    foreach (extreme_px[k]) send_pixel(extreme_px[k]);
    frame_setups++;

    // Zero sizes act as a 1x1 frame; two pixels also cover the wrap into the next frame.
    wait_idle();
    write_cfg(REG_FRAME_ROWS, 0);
    write_cfg(REG_FRAME_COLS, 0);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);

    // Single row, then single column.
    wait_idle();
    write_cfg(REG_FRAME_ROWS, 1);
    write_cfg(REG_FRAME_COLS, 3);
    repeat (3) send_pixel(rand_pixel());
    wait_idle();
    write_cfg(REG_FRAME_ROWS, 3);
    write_cfg(REG_FRAME_COLS, 1);
    repeat (3) send_pixel(rand_pixel());

    // Kernel change in the middle of a 2x2 frame.
    wait_idle();
    write_cfg(REG_FRAME_ROWS, 2);
    write_cfg(REG_FRAME_COLS, 2);
    repeat (2) send_pixel(rand_pixel());
    wait_idle();
    write_cfg(REG_KERNEL_MID, rand_kernel_row());
    repeat (2) send_pixel(rand_pixel());
    frame_setups += 4;

    // Random frames under four handshake modes: free flow, idle sender,
    // stalling receiver, both.
    for (int mode = 0; mode < 4; mode++) begin
      sender_idle_pct    = (mode == 1) ? 48 : (mode == 3) ? 35 : 0;
      receiver_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 35 : 0;
      wait_idle();
      write_cfg(c2d_reg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'({$urandom, $urandom}));

      // Full-depth frames: a tall one-column frame whose row size is oversized and
      // carries junk above the size byte, and a one-row frame exactly as wide as the buffers.
      if (mode == 1 || mode == 2) begin
        if (mode == 1) begin
          rows_w = CFG_DATA_W'({$urandom, $urandom});
          rows_w[FRAME_REG_W-1:0] = FRAME_REG_W'($urandom_range(MAX_DIM + 1, 255));
          cols_w = 1;
        end else begin
          rows_w = 1;
          cols_w = CFG_DATA_W'(MAX_DIM);
        end
        for (int k = 0; k < KSIZE; k++)
          write_cfg(REG_KERNEL_TOP + c2d_reg_idx_t'(k), rand_kernel_row());
        write_cfg(REG_FRAME_ROWS, rows_w);
        write_cfg(REG_FRAME_COLS, cols_w);
        repeat (MAX_DIM) send_pixel(rand_pixel());
        frame_setups++;
      end

      mode_px = 0;
      while (mode_px < SMALL_PX) begin
        wait_idle();
        for (int k = 0; k < KSIZE; k++)
          write_cfg(REG_KERNEL_TOP + c2d_reg_idx_t'(k), rand_kernel_row());
        // Without a size write the stream simply continues where it stopped.
        resize = (mode_px == 0) || ($urandom_range(3) != 0);
        if (resize) begin
          write_cfg(REG_FRAME_ROWS, CFG_DATA_W'($urandom_range(0, 6)));
          write_cfg(REG_FRAME_COLS, CFG_DATA_W'($urandom_range(0, 10)));
        end
        frame_px = sb.clamp_dim(sb.rows_cfg) * sb.clamp_dim(sb.cols_cfg);
        if ($urandom_range(4) == 0) frame_px = $urandom_range(1, frame_px);
        repeat (frame_px) send_pixel(rand_pixel());
        mode_px += frame_px;
        frame_setups++;
      end
    end

    wait_idle();
    $display("Sent %0d pixels over %0d frame setups, with and without idling on each side.",
             sb.pixels_taken, frame_setups);
    $display("Compared %0d results, %0d mismatches.", sb.results_checked, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
